// ----- rtl/bsie_pkg.sv -----
`default_nettype none

package bsie_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4,
		ST_CLEARED   = 3'd5
	} status_t;

	typedef struct packed {
		logic key_we;
		logic left_we;
		logic right_we;
	} pool_wr_t;

endpackage

`default_nettype wire

// ----- rtl/bsie_pool.sv -----
`default_nettype none

module bsie_pool #(
	parameter int unsigned IDX_W = 8
) (
	input  wire logic                    clk,
	input  wire logic [IDX_W-1:0]        rd_addr,
	output logic signed [31:0]           key_rd,
	output logic [IDX_W-1:0]             left_rd,
	output logic [IDX_W-1:0]             right_rd,
	input  wire bsie_pkg::pool_wr_t      wr,
	input  wire logic [IDX_W-1:0]        key_wa,
	input  wire logic signed [31:0]      key_wd,
	input  wire logic [IDX_W-1:0]        left_wa,
	input  wire logic [IDX_W-1:0]        left_wd,
	input  wire logic [IDX_W-1:0]        right_wa,
	input  wire logic [IDX_W-1:0]        right_wd
);

	localparam int unsigned DEPTH = 1 << IDX_W;

	logic signed [31:0] key_mem   [DEPTH];
	logic [IDX_W-1:0]   left_mem  [DEPTH];
	logic [IDX_W-1:0]   right_mem [DEPTH];

	logic signed [31:0] key_rd_q;
	logic [IDX_W-1:0]   left_rd_q;
	logic [IDX_W-1:0]   right_rd_q;

	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_mem[key_wa] <= key_wd;
		end
		key_rd_q <= key_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.left_we) begin
			left_mem[left_wa] <= left_wd;
		end
		left_rd_q <= left_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.right_we) begin
			right_mem[right_wa] <= right_wd;
		end
		right_rd_q <= right_mem[rd_addr];
	end

	assign key_rd   = key_rd_q;
	assign left_rd  = left_rd_q;
	assign right_rd = right_rd_q;

endmodule

`default_nettype wire

// ----- rtl/bst_insert_search_engine.sv -----
`default_nettype none

// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_ready   operation[1:0], key[31:0] signed
// response  out        rsp_valid/rsp_ready   status[2:0], node_index[7:0]
//
// An insert that links a new node walks the tree (S_WALK), writes the node (S_NODE) and
// links it to its parent (S_LINK) before responding; a first insert only writes the root,
// a search or a rejected insert walks and then responds, clear and unused codes respond at once.
// The walk is set by the single registered read port of the node pool: one node per cycle.
// Reset empties the tree at once; pool contents stay undefined until written, no clearing pass.
// A request is taken only while no walk is running; a stalled response holds the engine
// before it returns to idle, and a new request may be taken while a response waits.

module bst_insert_search_engine #(
	parameter int unsigned MAX_NODES = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire logic [1:0]         operation,
	input  wire logic signed [31:0] key,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output logic [2:0]              status,
	output logic [7:0]              node_index
);

	localparam int unsigned IDX_W = $clog2(MAX_NODES);
	localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_WALK = 5'b00010,
		S_NODE = 5'b00100,
		S_LINK = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                 state_q;
	logic                   insert_q;
	logic signed [31:0]     key_q;
	logic [IDX_W-1:0]       cur_q;
	logic [IDX_W-1:0]       parent_q;
	logic [IDX_W-1:0]       new_q;
	logic                   go_right_q;
	logic                   link_q;
	logic [CNT_W-1:0]       steps_q;
	logic [CNT_W-1:0]       count_q;
	bsie_pkg::status_t      res_status_q;
	logic [7:0]             res_index_q;
	logic                   rsp_valid_q;
	logic [2:0]             status_q;
	logic [7:0]             node_index_q;

	logic [IDX_W-1:0]       rd_addr;
	logic signed [31:0]     key_rd;
	logic [IDX_W-1:0]       left_rd;
	logic [IDX_W-1:0]       right_rd;
	bsie_pkg::pool_wr_t     wr;
	logic [IDX_W-1:0]       left_wa;
	logic [IDX_W-1:0]       left_wd;
	logic [IDX_W-1:0]       right_wa;
	logic [IDX_W-1:0]       right_wd;

	logic                   accept;
	logic                   hit;
	logic                   go_right;
	logic [IDX_W-1:0]       nxt;
	logic                   guard;
	logic                   full;
	logic                   rsp_free;

	assign accept   = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign hit      = (key_rd == key_q);
	assign go_right = (key_rd < key_q);
	assign nxt      = go_right ? right_rd : left_rd;
	assign guard    = (steps_q == CNT_W'(MAX_NODES));
	assign full     = (count_q == CNT_W'(MAX_NODES));
	assign rsp_free = !rsp_valid_q || rsp_ready;

	// follow the chosen link while walking, otherwise keep the root on the read port
	always_comb begin
		rd_addr = '0;
		if (state_q == S_WALK) begin
			rd_addr = nxt;
		end
	end

	always_comb begin
		wr       = '0;
		left_wa  = new_q;
		left_wd  = '0;
		right_wa = new_q;
		right_wd = '0;
		if (state_q == S_NODE) begin
			wr.key_we   = 1'b1;
			wr.left_we  = 1'b1;
			wr.right_we = 1'b1;
		end else if (state_q == S_LINK) begin
			wr.left_we  = !go_right_q;
			wr.right_we = go_right_q;
			left_wa     = parent_q;
			left_wd     = new_q;
			right_wa    = parent_q;
			right_wd    = new_q;
		end
	end

	bsie_pool #(
		.IDX_W (IDX_W)
	) u_pool (
		.clk      (clk),
		.rd_addr  (rd_addr),
		.key_rd   (key_rd),
		.left_rd  (left_rd),
		.right_rd (right_rd),
		.wr       (wr),
		.key_wa   (new_q),
		.key_wd   (key_q),
		.left_wa  (left_wa),
		.left_wd  (left_wd),
		.right_wa (right_wa),
		.right_wd (right_wd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (operation)
							bsie_pkg::OP_INSERT: begin
								state_q <= (count_q == '0) ? S_NODE : S_WALK;
							end
							bsie_pkg::OP_SEARCH: begin
								state_q <= (count_q == '0) ? S_DONE : S_WALK;
							end
							bsie_pkg::OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_WALK: begin
					if (guard || hit) begin
						state_q <= S_DONE;
					end else if (nxt == '0) begin
						state_q <= (insert_q && !full) ? S_NODE : S_DONE;
					end
				end
				S_NODE: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= link_q ? S_LINK : S_DONE;
				end
				S_LINK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				insert_q    <= (operation == bsie_pkg::OP_INSERT);
				key_q       <= key;
				cur_q       <= '0;
				steps_q     <= '0;
				new_q       <= '0;
				link_q      <= 1'b0;
				res_index_q <= '0;
				unique case (operation)
					bsie_pkg::OP_INSERT: res_status_q <= bsie_pkg::ST_INSERTED;
					bsie_pkg::OP_CLEAR:  res_status_q <= bsie_pkg::ST_CLEARED;
					default:             res_status_q <= bsie_pkg::ST_NOT_FOUND;
				endcase
			end
			S_WALK: begin
				if (guard) begin
					res_status_q <= insert_q ? bsie_pkg::ST_FULL : bsie_pkg::ST_NOT_FOUND;
				end else if (hit) begin
					res_status_q <= insert_q ? bsie_pkg::ST_DUPLICATE : bsie_pkg::ST_FOUND;
					res_index_q  <= insert_q ? 8'd0 : 8'(cur_q);
				end else if (nxt == '0) begin
					parent_q   <= cur_q;
					go_right_q <= go_right;
					new_q      <= count_q[IDX_W-1:0];
					link_q     <= 1'b1;
					if (!insert_q) begin
						res_status_q <= bsie_pkg::ST_NOT_FOUND;
					end else if (full) begin
						res_status_q <= bsie_pkg::ST_FULL;
					end else begin
						res_status_q <= bsie_pkg::ST_INSERTED;
						res_index_q  <= 8'(count_q);
					end
				end else begin
					cur_q   <= nxt;
					steps_q <= steps_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// hold the response until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && rsp_free) begin
			status_q     <= res_status_q;
			node_index_q <= res_index_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign node_index = node_index_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_NODES))
		else $error("node count beyond pool size");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == bsie_pkg::OP_CLEAR) |=> (count_q == '0))
		else $error("clear did not empty the tree");

	a_insert_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_status_q == bsie_pkg::ST_INSERTED)
			|-> (res_index_q == 8'(count_q - CNT_W'(1))))
		else $error("inserted index does not match the last allocated node");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (steps_q <= CNT_W'(MAX_NODES)))
		else $error("walk ran past the step guard");

endmodule

`default_nettype wire
